/* design/pic_pkg.sv */
// ----------------------------------------------------------------------------
// pic_pkg
// shared types, constants and term helpers for the prime implicant cover block
// ----------------------------------------------------------------------------
`default_nettype none

package pic_pkg;

   localparam int MAX_VARS        = 6;
   localparam int TABLE_W         = 64;
   localparam int NV_W            = 3;
   localparam int FIELD_W         = 6;
   localparam int CODE_W          = 2 * FIELD_W;
   localparam int RESULT_LIMIT    = 32;
   localparam int PRIME_ADDR_W    = 12;
   localparam int PRIME_CNT_W     = PRIME_ADDR_W + 1;
   localparam int DEF_ROUND_TERMS = 256;
   localparam int DEF_PRIME_SLOTS = 1024;

   typedef struct packed {
      logic [FIELD_W-1:0] care;
      logic [FIELD_W-1:0] value;
   } term_type;

   typedef struct packed {
      logic [TABLE_W-1:0] table_bits;
      logic [NV_W-1:0]    nv;
   } job_type;

   typedef struct packed {
      logic    valid;
      job_type job;
   } queue_out_type;

   typedef struct packed {
      logic                    en;
      logic [PRIME_ADDR_W-1:0] addr;
      term_type                term;
   } prime_wr_type;

   typedef struct packed {
      logic                   start;
      logic [TABLE_W-1:0]     table_bits;
      logic [PRIME_CNT_W-1:0] nprime;
   } cover_start_type;

   function automatic logic [TABLE_W-1:0] term_cover(input term_type t);
      logic [TABLE_W-1:0] cov;
      cov = '0;
      for (int k = 0; k < TABLE_W; k++) begin
         cov[k] = ((FIELD_W'(k) & t.care) == t.value);
      end
      return cov;
   endfunction

   function automatic logic [TABLE_W-1:0] table_mask(input logic [NV_W-1:0] nv);
      logic [TABLE_W-1:0] m;
      m = '0;
      for (int k = 0; k < TABLE_W; k++) begin
         m[k] = (k < (1 << nv));
      end
      return m;
   endfunction

endpackage

`default_nettype wire

/* design/pic_front.sv */
// ----------------------------------------------------------------------------
// pic_front
// accepts words, clamps the variable count, masks the table, queues jobs
// ----------------------------------------------------------------------------
`default_nettype none

module pic_front
   import pic_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [TABLE_W-1:0] req_truth_table,
   input  wire logic [NV_W-1:0]    req_num_vars,
   input  wire logic               engine_ready,
   input  wire logic               pop,
   output queue_out_type           job_q
);

   localparam int QDepth = 2;
   localparam int QPtrW  = $clog2(QDepth);

   job_type            q_mem_ff [QDepth];
   logic [QPtrW-1:0]   wr_ptr_ff;
   logic [QPtrW-1:0]   rd_ptr_ff;
   logic [QPtrW:0]     count_ff;
   logic [NV_W-1:0]    nv_sat;
   job_type            job_new;
   logic               push;

   always_comb begin
      nv_sat = (req_num_vars > NV_W'(MAX_VARS)) ? NV_W'(MAX_VARS) : req_num_vars;
      job_new.nv         = nv_sat;
      job_new.table_bits = req_truth_table & table_mask(nv_sat);
   end

   assign req_ready   = engine_ready && (count_ff != (QPtrW+1)'(QDepth));
   assign push        = req_valid && req_ready;
   assign job_q.valid = (count_ff != '0);
   assign job_q.job   = q_mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem_ff[wr_ptr_ff] <= job_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         case ({push, pop})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

`default_nettype wire

/* design/pic_merge.sv */
// ----------------------------------------------------------------------------
// pic_merge
// builds the prime implicants of one job by rounds of pairwise merging
// ----------------------------------------------------------------------------
`default_nettype none

module pic_merge
   import pic_pkg::*;
#(
   parameter int ROUND_TERMS = DEF_ROUND_TERMS,
   parameter int PRIME_SLOTS = DEF_PRIME_SLOTS
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire queue_out_type job_q,
   output logic               pop,
   output logic               ready,
   input  wire logic          cover_busy,
   output prime_wr_type       prime_wr,
   output cover_start_type    cover_start
);

   localparam int RW = $clog2(ROUND_TERMS);
   localparam int PW = $clog2(PRIME_SLOTS);

   typedef enum logic [3:0] {
      M_SWEEP, M_IDLE, M_LOAD, M_RINIT, M_ILOAD, M_ICAP, M_CMP, M_SEEN,
      M_JREAD, M_WRD, M_WWR, M_CRD, M_CWR, M_SWAP, M_DONE
   } state_type;

   state_type            state_ff;
   logic [TABLE_W-1:0]   tt_ff;
   logic [FIELD_W-1:0]   vfull_ff;
   logic [FIELD_W-1:0]   k_ff;
   logic                 bank_ff;
   logic [RW:0]          ncur_ff;
   logic [RW:0]          nnext_ff;
   logic [PW:0]          nprime_ff;
   logic [RW-1:0]        i_ff;
   logic [RW-1:0]        j_ff;
   logic [CODE_W-1:0]    sweep_ff;
   term_type             term_i_ff;
   term_type             grown_ff;

   term_type             term_mem [2*ROUND_TERMS];
   term_type             rd_ff;
   logic                 seen_mem [1 << CODE_W];
   logic                 seen_rd_ff;
   logic                 mark_mem [ROUND_TERMS];
   logic                 mark_rd_ff;

   logic                 rd_bank;
   logic [RW-1:0]        rd_idx;
   logic                 tw_en;
   logic                 tw_bank;
   logic [RW-1:0]        tw_idx;
   term_type             tw_data;
   logic                 sw_en;
   logic [CODE_W-1:0]    sw_addr;
   logic                 sw_data;
   logic                 mark_we;
   logic [RW-1:0]        mark_addr;
   logic                 mark_data;
   logic [FIELD_W-1:0]   diff;
   logic                 mergeable;
   term_type             grown_c;
   logic                 last_j;
   logic                 last_i;
   logic                 new_term;
   logic                 prime_en;

   always_comb begin
      diff      = (term_i_ff.value ^ rd_ff.value) & term_i_ff.care;
      mergeable = (term_i_ff.care == rd_ff.care) && (diff != '0)
                  && ((diff & (diff - 1'b1)) == '0);
      grown_c.care  = term_i_ff.care & ~diff;
      grown_c.value = term_i_ff.value & ~diff;
      last_j    = (({1'b0, j_ff} + 1'b1) == ncur_ff);
      last_i    = (({1'b0, i_ff} + (RW+1)'(2)) == ncur_ff);
      new_term  = !seen_rd_ff && (nnext_ff < (RW+1)'(ROUND_TERMS));
      prime_en  = !mark_rd_ff && (nprime_ff < (PW+1)'(PRIME_SLOTS));
   end

   always_comb begin
      rd_bank   = bank_ff;
      rd_idx    = i_ff;
      tw_en     = 1'b0;
      tw_bank   = bank_ff;
      tw_idx    = ncur_ff[RW-1:0];
      tw_data   = '{care: vfull_ff, value: k_ff};
      sw_en     = 1'b0;
      sw_addr   = grown_ff;
      sw_data   = 1'b0;
      mark_we   = 1'b0;
      mark_addr = i_ff;
      mark_data = 1'b0;
      case (state_ff)
         M_SWEEP: begin
            sw_en     = 1'b1;
            sw_addr   = sweep_ff;
            mark_we   = 1'b1;
            mark_addr = sweep_ff[RW-1:0];
         end
         M_LOAD: begin
            tw_en = tt_ff[k_ff] && (ncur_ff < (RW+1)'(ROUND_TERMS));
         end
         M_ICAP: rd_idx = i_ff + 1'b1;
         M_CMP: begin
            rd_idx    = j_ff + 1'b1;
            mark_we   = mergeable;
            mark_addr = j_ff;
            mark_data = 1'b1;
         end
         M_JREAD: rd_idx = j_ff;
         M_SEEN: begin
            tw_en     = new_term;
            tw_bank   = ~bank_ff;
            tw_idx    = nnext_ff[RW-1:0];
            tw_data   = grown_ff;
            sw_en     = new_term;
            sw_data   = 1'b1;
            mark_we   = 1'b1;
            mark_data = 1'b1;
         end
         M_WWR: mark_we = 1'b1;
         M_CRD: rd_bank = ~bank_ff;
         M_CWR: begin
            sw_en   = 1'b1;
            sw_addr = rd_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (tw_en) begin
         term_mem[{tw_bank, tw_idx}] <= tw_data;
      end
      rd_ff <= term_mem[{rd_bank, rd_idx}];
   end

   always_ff @(posedge clock) begin
      if (sw_en) begin
         seen_mem[sw_addr] <= sw_data;
      end
      seen_rd_ff <= seen_mem[grown_c];
   end

   // merged flags, cleared again as each term is read out
   always_ff @(posedge clock) begin
      if (mark_we) begin
         mark_mem[mark_addr] <= mark_data;
      end
      mark_rd_ff <= mark_mem[i_ff];
   end

   assign pop   = (state_ff == M_IDLE) && job_q.valid && !cover_busy;
   assign ready = (state_ff != M_SWEEP);

   assign prime_wr.en   = (state_ff == M_WWR) && prime_en;
   assign prime_wr.addr = PRIME_ADDR_W'(nprime_ff[PW-1:0]);
   assign prime_wr.term = rd_ff;

   assign cover_start.start      = (state_ff == M_DONE);
   assign cover_start.table_bits = tt_ff;
   assign cover_start.nprime     = PRIME_CNT_W'(nprime_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= M_SWEEP;
         sweep_ff <= '0;
      end else begin
         case (state_ff)
            M_SWEEP: begin
               sweep_ff <= sweep_ff + 1'b1;
               if (sweep_ff == '1) begin
                  state_ff <= M_IDLE;
               end
            end
            M_IDLE: begin
               if (pop) begin
                  tt_ff     <= job_q.job.table_bits;
                  vfull_ff  <= FIELD_W'(((FIELD_W+1)'(1) << job_q.job.nv) - 1'b1);
                  k_ff      <= '0;
                  ncur_ff   <= '0;
                  nprime_ff <= '0;
                  bank_ff   <= 1'b0;
                  state_ff  <= M_LOAD;
               end
            end
            M_LOAD: begin
               if (tw_en) begin
                  ncur_ff <= ncur_ff + 1'b1;
               end
               k_ff <= k_ff + 1'b1;
               if (k_ff == vfull_ff) begin
                  state_ff <= M_RINIT;
               end
            end
            M_RINIT: begin
               nnext_ff <= '0;
               i_ff     <= '0;
               if (ncur_ff == '0) begin
                  state_ff <= M_DONE;
               end else if (ncur_ff == (RW+1)'(1)) begin
                  state_ff <= M_WRD;
               end else begin
                  state_ff <= M_ILOAD;
               end
            end
            M_ILOAD: state_ff <= M_ICAP;
            M_ICAP: begin
               term_i_ff <= rd_ff;
               j_ff      <= i_ff + 1'b1;
               state_ff  <= M_CMP;
            end
            M_CMP: begin
               if (mergeable) begin
                  grown_ff <= grown_c;
                  state_ff <= M_SEEN;
               end else if (last_j) begin
                  if (last_i) begin
                     i_ff     <= '0;
                     state_ff <= M_WRD;
                  end else begin
                     i_ff     <= i_ff + 1'b1;
                     state_ff <= M_ILOAD;
                  end
               end else begin
                  j_ff <= j_ff + 1'b1;
               end
            end
            M_SEEN: begin
               if (new_term) begin
                  nnext_ff <= nnext_ff + 1'b1;
               end
               if (last_j) begin
                  if (last_i) begin
                     i_ff     <= '0;
                     state_ff <= M_WRD;
                  end else begin
                     i_ff     <= i_ff + 1'b1;
                     state_ff <= M_ILOAD;
                  end
               end else begin
                  j_ff     <= j_ff + 1'b1;
                  state_ff <= M_JREAD;
               end
            end
            M_JREAD: state_ff <= M_CMP;
            M_WRD:   state_ff <= M_WWR;
            M_WWR: begin
               if (prime_en) begin
                  nprime_ff <= nprime_ff + 1'b1;
               end
               if (({1'b0, i_ff} + 1'b1) == ncur_ff) begin
                  i_ff     <= '0;
                  state_ff <= (nnext_ff == '0) ? M_SWAP : M_CRD;
               end else begin
                  i_ff     <= i_ff + 1'b1;
                  state_ff <= M_WRD;
               end
            end
            M_CRD: state_ff <= M_CWR;
            M_CWR: begin
               if (({1'b0, i_ff} + 1'b1) == nnext_ff) begin
                  state_ff <= M_SWAP;
               end else begin
                  i_ff     <= i_ff + 1'b1;
                  state_ff <= M_CRD;
               end
            end
            M_SWAP: begin
               bank_ff  <= ~bank_ff;
               ncur_ff  <= nnext_ff;
               state_ff <= M_RINIT;
            end
            M_DONE:  state_ff <= M_IDLE;
            default: state_ff <= M_IDLE;
         endcase
      end
   end

endmodule

`default_nettype wire

/* design/pic_cover.sv */
// ----------------------------------------------------------------------------
// pic_cover
// greedy cover over the prime list, one scan per chosen term, result register
// ----------------------------------------------------------------------------
`default_nettype none

module pic_cover
   import pic_pkg::*;
#(
   parameter int PRIME_SLOTS = DEF_PRIME_SLOTS
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire prime_wr_type    prime_wr,
   input  wire cover_start_type cover_start,
   output logic                 busy,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   output logic [FIELD_W-1:0]   rsp_term_value,
   output logic [FIELD_W-1:0]   rsp_term_care,
   output logic                 rsp_empty_sum,
   output logic                 rsp_last_term
);

   localparam int PW     = $clog2(PRIME_SLOTS);
   localparam int GAIN_W = $clog2(TABLE_W) + 1;
   localparam int PARTS  = TABLE_W / 8;
   localparam int NW     = $clog2(RESULT_LIMIT) + 1;

   typedef enum logic [2:0] {
      C_IDLE, C_SCAN, C_PICK, C_WMID, C_NEXT, C_WEND
   } state_type;

   state_type           state_ff;
   term_type            prime_mem [PRIME_SLOTS];
   term_type            prime_rd_ff;
   logic [TABLE_W-1:0]  unc_ff;
   logic [PW:0]         np_ff;
   logic [PW:0]         p_ff;
   logic [NW-1:0]       n_ff;
   logic                have_pend_ff;
   term_type            pend_ff;
   term_type            best_term_ff;
   logic [GAIN_W-1:0]   best_gain_ff;
   logic                v1_ff, v2_ff, v3_ff, v4_ff;
   logic [TABLE_W-1:0]  hit_ff;
   term_type            t2_ff, t3_ff, t4_ff;
   logic [3:0]          part_ff [PARTS];
   logic [GAIN_W-1:0]   gain_ff;
   logic                out_valid_ff;
   logic [FIELD_W-1:0]  out_value_ff;
   logic [FIELD_W-1:0]  out_care_ff;
   logic                out_empty_ff;
   logic                out_last_ff;

   logic                issue;
   logic                scan_end;
   logic                out_take;
   logic [3:0]          part_c [PARTS];
   logic [GAIN_W-1:0]   gain_c;

   assign issue    = (state_ff == C_SCAN) && (p_ff != np_ff);
   assign scan_end = (state_ff == C_SCAN) && (p_ff == np_ff)
                     && !v1_ff && !v2_ff && !v3_ff && !v4_ff;
   assign out_take = out_valid_ff && rsp_ready;
   assign busy     = (state_ff != C_IDLE);

   assign rsp_valid      = out_valid_ff;
   assign rsp_term_value = out_value_ff;
   assign rsp_term_care  = out_care_ff;
   assign rsp_empty_sum  = out_empty_ff;
   assign rsp_last_term  = out_last_ff;

   always_ff @(posedge clock) begin
      if (prime_wr.en) begin
         prime_mem[prime_wr.addr[PW-1:0]] <= prime_wr.term;
      end
      prime_rd_ff <= prime_mem[p_ff[PW-1:0]];
   end

   always_comb begin
      for (int b = 0; b < PARTS; b++) begin
         part_c[b] = '0;
         for (int q = 0; q < 8; q++) begin
            part_c[b] = part_c[b] + 4'(hit_ff[8*b+q]);
         end
      end
      gain_c = '0;
      for (int b = 0; b < PARTS; b++) begin
         gain_c = gain_c + GAIN_W'(part_ff[b]);
      end
   end

   // gain pipeline: cover mask, byte counts, total
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= issue;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
      hit_ff  <= term_cover(prime_rd_ff) & unc_ff;
      t2_ff   <= prime_rd_ff;
      part_ff <= part_c;
      t3_ff   <= t2_ff;
      gain_ff <= gain_c;
      t4_ff   <= t3_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= C_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            C_IDLE: begin
               if (cover_start.start) begin
                  unc_ff       <= cover_start.table_bits;
                  np_ff        <= cover_start.nprime[PW:0];
                  n_ff         <= '0;
                  have_pend_ff <= 1'b0;
                  p_ff         <= '0;
                  best_gain_ff <= '0;
                  state_ff     <= C_SCAN;
               end
            end
            C_SCAN: begin
               if (issue) begin
                  p_ff <= p_ff + 1'b1;
               end
               if (v4_ff && (gain_ff > best_gain_ff)) begin
                  best_gain_ff <= gain_ff;
                  best_term_ff <= t4_ff;
               end
               if (scan_end) begin
                  state_ff <= C_PICK;
               end
            end
            C_PICK: begin
               if (best_gain_ff == '0) begin
                  out_valid_ff <= 1'b1;
                  out_value_ff <= have_pend_ff ? pend_ff.value : '0;
                  out_care_ff  <= have_pend_ff ? pend_ff.care : '0;
                  out_empty_ff <= !have_pend_ff;
                  out_last_ff  <= 1'b1;
                  state_ff     <= C_WEND;
               end else begin
                  unc_ff       <= unc_ff & ~term_cover(best_term_ff);
                  n_ff         <= n_ff + 1'b1;
                  pend_ff      <= best_term_ff;
                  have_pend_ff <= 1'b1;
                  if (have_pend_ff) begin
                     out_valid_ff <= 1'b1;
                     out_value_ff <= pend_ff.value;
                     out_care_ff  <= pend_ff.care;
                     out_empty_ff <= 1'b0;
                     out_last_ff  <= 1'b0;
                     state_ff     <= C_WMID;
                  end else begin
                     state_ff <= C_NEXT;
                  end
               end
            end
            C_WMID: begin
               if (out_take) begin
                  out_valid_ff <= 1'b0;
                  state_ff     <= C_NEXT;
               end
            end
            C_NEXT: begin
               if ((unc_ff == '0) || (n_ff == NW'(RESULT_LIMIT))) begin
                  out_valid_ff <= 1'b1;
                  out_value_ff <= pend_ff.value;
                  out_care_ff  <= pend_ff.care;
                  out_empty_ff <= 1'b0;
                  out_last_ff  <= 1'b1;
                  state_ff     <= C_WEND;
               end else begin
                  p_ff         <= '0;
                  best_gain_ff <= '0;
                  state_ff     <= C_SCAN;
               end
            end
            C_WEND: begin
               if (out_take) begin
                  out_valid_ff <= 1'b0;
                  state_ff     <= C_IDLE;
               end
            end
            default: state_ff <= C_IDLE;
         endcase
      end
   end

endmodule

`default_nettype wire

/* design/prime_implicant_greedy_cover_top.sv */
// ----------------------------------------------------------------------------
// prime_implicant_greedy_cover_top
// sum-of-products minimizer: prime implicants by merging, then greedy cover
// ----------------------------------------------------------------------------
// One word carries a truth table of up to 64 bits and a variable count (values
// above six are taken as six). The block answers with one word per chosen
// product term, last_term marking the final one, or a single word with
// empty_sum set when the function is constant zero. After reset the block
// clears its 4096-entry duplicate-check memory, one entry a cycle, and takes
// no word until it is done. A two-entry queue takes up to two words while
// earlier ones are worked on. Each word then goes through these steps: load
// the minterms, then merge rounds that compare every pair of terms through the
// single read port of the term memory, check each merged term against the
// duplicate-check memory, write the unmerged terms out as primes and clear the
// duplicate-check entries of the new terms; then per chosen term one scan of
// the prime list plus the output handshake. Items are processed one at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module prime_implicant_greedy_cover_top
   import pic_pkg::*;
#(
   parameter int ROUND_TERMS = DEF_ROUND_TERMS,
   parameter int PRIME_SLOTS = DEF_PRIME_SLOTS
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [TABLE_W-1:0] req_truth_table,
   input  wire logic [NV_W-1:0]    req_num_vars,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [FIELD_W-1:0]      rsp_term_value,
   output logic [FIELD_W-1:0]      rsp_term_care,
   output logic                    rsp_empty_sum,
   output logic                    rsp_last_term
);

   queue_out_type   job_q;
   logic            pop;
   logic            engine_ready;
   logic            cover_busy;
   prime_wr_type    prime_wr;
   cover_start_type cover_start;

   pic_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_truth_table (req_truth_table),
      .req_num_vars    (req_num_vars),
      .engine_ready    (engine_ready),
      .pop             (pop),
      .job_q           (job_q)
   );

   pic_merge #(
      .ROUND_TERMS (ROUND_TERMS),
      .PRIME_SLOTS (PRIME_SLOTS)
   ) u_merge (
      .clock       (clock),
      .reset       (reset),
      .job_q       (job_q),
      .pop         (pop),
      .ready       (engine_ready),
      .cover_busy  (cover_busy),
      .prime_wr    (prime_wr),
      .cover_start (cover_start)
   );

   pic_cover #(
      .PRIME_SLOTS (PRIME_SLOTS)
   ) u_cover (
      .clock          (clock),
      .reset          (reset),
      .prime_wr       (prime_wr),
      .cover_start    (cover_start),
      .busy           (cover_busy),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_term_value (rsp_term_value),
      .rsp_term_care  (rsp_term_care),
      .rsp_empty_sum  (rsp_empty_sum),
      .rsp_last_term  (rsp_last_term)
   );

   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_empty_sum |-> rsp_last_term && (rsp_term_care == '0))
      else $error("empty word not final or carries a care mask");

   a_value_in_care: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_term_value & ~rsp_term_care) == '0))
      else $error("term value outside its care mask");

   a_no_start_when_busy: assert property (@(posedge clock) disable iff (reset)
      cover_start.start |-> !cover_busy)
      else $error("cover started while still busy");

   a_no_prime_write_when_busy: assert property (@(posedge clock) disable iff (reset)
      prime_wr.en |-> !cover_busy)
      else $error("prime list written during cover");

endmodule

`default_nettype wire
